>>> design/ycr_pkg.sv
// ----------------------------------------------------------------------------
// ycr_pkg
// Shared types and constants for the YUYV crop and RGB converter.
// ----------------------------------------------------------------------------
package ycr_pkg;

    // Largest frame dimension the counters track
    localparam int MAX_FRAME_DIM = 4096;
    localparam int COL_W         = $clog2(MAX_FRAME_DIM / 2);
    localparam int ROW_W         = $clog2(MAX_FRAME_DIM);
    // Working width for window edge math (12 + 13 bit sums)
    localparam int WIDE_W        = 15;

    // Configuration register map
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [12:0] RST_FRAME_WIDTH = 13'd1920;
    localparam logic [11:0] RST_CROP_LEFT   = 12'd448;
    localparam logic [11:0] RST_CROP_TOP    = 12'd83;
    localparam logic [12:0] RST_CROP_WIDTH  = 13'd1024;
    localparam logic [12:0] RST_CROP_HEIGHT = 13'd912;

    // BT.601 style coefficients, scaled by 256
    localparam logic signed [9:0] K_RV = 10'sd359;
    localparam logic signed [9:0] K_GU = 10'sd88;
    localparam logic signed [9:0] K_GV = 10'sd183;
    localparam logic signed [9:0] K_BU = 10'sd454;

    // Where the current pair lies relative to the crop window
    typedef struct packed {
        logic in_window;
        logic row_last;
        logic frame_last;
    } t_loc;

    // Chroma offsets shared by both pixels of a pair
    typedef struct packed {
        logic signed [8:0] dr;
        logic signed [8:0] dg;
        logic signed [8:0] db;
    } t_chroma;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

>>> design/ycr_locator.sv
// ----------------------------------------------------------------------------
// ycr_locator
// Config registers, pair/row counters and crop window test.
// ----------------------------------------------------------------------------
module ycr_locator
    import ycr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    input  logic                  i_frame_start,
    output t_loc                  o_loc
);

    logic [12:0]      r_frame_width;
    logic [11:0]      r_crop_left;
    logic [11:0]      r_crop_top;
    logic [12:0]      r_crop_width;
    logic [12:0]      r_crop_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [WIDE_W-1:0] fw_clip;
    logic [WIDE_W-1:0] ppr;
    logic [WIDE_W-1:0] col_w;
    logic [WIDE_W-1:0] row_w;
    logic [WIDE_W-1:0] left;
    logic [WIDE_W-1:0] right_raw;
    logic [WIDE_W-1:0] right;
    logic [WIDE_W-1:0] top;
    logic [WIDE_W-1:0] bottom_raw;
    logic [WIDE_W-1:0] bottom;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= RST_FRAME_WIDTH;
            r_crop_left   <= RST_CROP_LEFT;
            r_crop_top    <= RST_CROP_TOP;
            r_crop_width  <= RST_CROP_WIDTH;
            r_crop_height <= RST_CROP_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH: r_frame_width <= i_cfg_data;
                REG_CROP_LEFT:   r_crop_left   <= i_cfg_data[11:0];
                REG_CROP_TOP:    r_crop_top    <= i_cfg_data[11:0];
                REG_CROP_WIDTH:  r_crop_width  <= i_cfg_data;
                REG_CROP_HEIGHT: r_crop_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // pairs per row, clipped to the tracked maximum, never zero
        fw_clip = (WIDE_W'(r_frame_width) > WIDE_W'(MAX_FRAME_DIM))
                ? WIDE_W'(MAX_FRAME_DIM) : WIDE_W'(r_frame_width);
        ppr = fw_clip >> 1;
        if (ppr == '0) begin
            ppr = WIDE_W'(1);
        end

        col = i_frame_start ? '0 : r_col;
        row = i_frame_start ? '0 : r_row;
        if (WIDE_W'(col) >= ppr) begin
            col = '0;
        end
        col_w = WIDE_W'(col);
        row_w = WIDE_W'(row);

        wrap  = (col_w + WIDE_W'(1)) >= ppr;
        n_col = wrap ? '0 : COL_W'(col_w + WIDE_W'(1));
        n_row = row;
        if (wrap && (row != ROW_W'(MAX_FRAME_DIM - 1))) begin
            n_row = row + ROW_W'(1);
        end

        left      = WIDE_W'(r_crop_left[11:1]);
        right_raw = left + ((WIDE_W'(r_crop_width) + WIDE_W'(1)) >> 1);
        right     = (right_raw > ppr) ? ppr : right_raw;
        top       = WIDE_W'(r_crop_top);
        bottom_raw = top + WIDE_W'(r_crop_height);
        bottom    = (bottom_raw > WIDE_W'(MAX_FRAME_DIM))
                  ? WIDE_W'(MAX_FRAME_DIM) : bottom_raw;

        o_loc.in_window  = (col_w >= left) && (col_w < right)
                        && (row_w >= top) && (row_w < bottom);
        o_loc.row_last   = (col_w + WIDE_W'(1)) == right;
        o_loc.frame_last = o_loc.row_last && ((row_w + WIDE_W'(1)) == bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> design/ycr_chroma.sv
// ----------------------------------------------------------------------------
// ycr_chroma
// Chroma offsets shared by both pixels: constant multiplies, floor by 256.
// ----------------------------------------------------------------------------
module ycr_chroma
    import ycr_pkg::*;
(
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    output t_chroma    o_chroma
);

    logic signed [17:0] uu;
    logic signed [17:0] vv;
    logic signed [17:0] prod_r;
    logic signed [17:0] prod_g;
    logic signed [17:0] prod_b;

    always_comb begin
        // sample minus 128 is the sample with its top bit flipped
        uu = 18'($signed({~i_chroma_blue[7], i_chroma_blue[6:0]}));
        vv = 18'($signed({~i_chroma_red[7], i_chroma_red[6:0]}));
        prod_r = 18'(K_RV) * vv;
        prod_g = (18'(K_GU) * uu) + (18'(K_GV) * vv);
        prod_b = 18'(K_BU) * uu;
        // arithmetic shift rounds toward minus infinity
        o_chroma.dr = 9'(prod_r >>> 8);
        o_chroma.dg = 9'(prod_g >>> 8);
        o_chroma.db = 9'(prod_b >>> 8);
    end

endmodule

>>> design/ycr_lane.sv
// ----------------------------------------------------------------------------
// ycr_lane
// One pixel: add chroma offsets to luma and clamp each channel to 8 bits.
// ----------------------------------------------------------------------------
module ycr_lane
    import ycr_pkg::*;
(
    input  logic [7:0] i_luma,
    input  t_chroma    i_chroma,
    output t_rgb       o_rgb
);

    function automatic logic [7:0] clamp8(input logic signed [9:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 10'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    logic signed [9:0] y_s;
    logic signed [9:0] sum_r;
    logic signed [9:0] sum_g;
    logic signed [9:0] sum_b;

    always_comb begin
        y_s   = $signed({2'b00, i_luma});
        sum_r = y_s + 10'($signed(i_chroma.dr));
        sum_g = y_s - 10'($signed(i_chroma.dg));
        sum_b = y_s + 10'($signed(i_chroma.db));
        o_rgb.red   = clamp8(sum_r);
        o_rgb.green = clamp8(sum_g);
        o_rgb.blue  = clamp8(sum_b);
    end

endmodule

>>> design/yuyv_crop_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// yuyv_crop_to_rgb_converter_top
// Crops a YUYV pair stream to a window and converts each pair to two RGB
// pixels.
// ----------------------------------------------------------------------------
// An accepted request is registered in stage 1 and then in the output register.
// Throughput: one pair per cycle unless the output stalls; the chroma stage and
//   the output register each hold one pair, so one more request is taken while a result waits.
// Pairs outside the crop window are accepted and dropped.
// Reset (synchronous, active low) loads the default window, clears the
//   pair/row counters and empties the pipeline.
// ----------------------------------------------------------------------------
module yuyv_crop_to_rgb_converter_top
    import ycr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input pair stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second,
    // [31:24] chroma_red
    input  logic [31:0]           s_axis_tdata,
    // [0] frame_start
    input  logic                  s_axis_tuser,
    // output RGB pair stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
    // [31:24] red_second, [39:32] green_second, [47:40] blue_second
    output logic [47:0]           m_axis_tdata,
    // row_last
    output logic                  m_axis_tlast,
    // [0] frame_last
    output logic                  m_axis_tuser
);

    // Handshake: each stage moves when the one after it is empty or moving
    logic adv_out;
    logic adv_s1;
    logic accept;

    t_loc    loc;
    t_chroma chroma;
    t_rgb    rgb_first;
    t_rgb    rgb_second;

    // Stage 1: luma plus registered chroma products
    logic       r_s1_valid;
    logic [7:0] r_s1_luma_first;
    logic [7:0] r_s1_luma_second;
    t_chroma    r_s1_chroma;
    logic       r_s1_row_last;
    logic       r_s1_frame_last;

    // Output register: merges the two pixel lanes
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_row_last;
    logic        r_out_frame_last;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign adv_s1        = !r_s1_valid || adv_out;
    assign s_axis_tready = adv_s1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Locates every accepted request, whether or not it is kept
    ycr_locator u_locator (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_step        (accept),
        .i_frame_start (s_axis_tuser),
        .o_loc         (loc)
    );

    ycr_chroma u_chroma (
        .i_chroma_blue (s_axis_tdata[15:8]),
        .i_chroma_red  (s_axis_tdata[31:24]),
        .o_chroma      (chroma)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= accept && loc.in_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_luma_first  <= s_axis_tdata[7:0];
            r_s1_luma_second <= s_axis_tdata[23:16];
            r_s1_chroma      <= chroma;
            r_s1_row_last    <= loc.row_last;
            r_s1_frame_last  <= loc.frame_last;
        end
    end

    // Two pixel lanes share the chroma offsets
    ycr_lane u_lane_first (
        .i_luma   (r_s1_luma_first),
        .i_chroma (r_s1_chroma),
        .o_rgb    (rgb_first)
    );

    ycr_lane u_lane_second (
        .i_luma   (r_s1_luma_second),
        .i_chroma (r_s1_chroma),
        .o_rgb    (rgb_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_data <= {rgb_second.blue, rgb_second.green, rgb_second.red,
                           rgb_first.blue, rgb_first.green, rgb_first.red};
            r_out_row_last   <= r_s1_row_last;
            r_out_frame_last <= r_s1_frame_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_row_last;
    assign m_axis_tuser  = r_out_frame_last;

    // End of the crop frame is always also the end of a crop row
    a_frame_last_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast || !m_axis_tuser))
        else $error("frame_last without row_last");

    // Input only stalls when both pipeline stages are full and blocked
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // Pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule
